FILE: src/vphs_pkg.sv
// shared codes and constants for the valve peak-and-hold sequencer
// no dependencies; imported by valve_peak_hold_sequencer
`timescale 1ns / 1ps
`default_nettype none

package vphs_pkg;

	// item kinds
	localparam logic [1:0] OP_STEP      = 2'd0;
	localparam logic [1:0] OP_COMMAND   = 2'd1;
	localparam logic [1:0] OP_TIMER_CLR = 2'd2;

	// command codes carried with OP_COMMAND
	localparam logic [1:0] CMD_FIRE  = 2'd0;
	localparam logic [1:0] CMD_OPEN  = 2'd1;
	localparam logic [1:0] CMD_CLOSE = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_NORMALLY_OPEN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRE_DELAY     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_DUTY_TIME = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_DUTY      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_DUTY      = 3'd4;

	localparam int unsigned TIMER_W = 32;
	localparam int unsigned ELAPSED_W = 16;
	localparam int unsigned DUTY_W = 8;

	localparam logic [DUTY_W-1:0] HOLD_DUTY_RST = 8'd50;
	localparam logic [DUTY_W-1:0] FULL_DUTY_RST = 8'd255;
	localparam logic [DUTY_W-1:0] DUTY_OFF      = 8'd0;

endpackage

`default_nettype wire

FILE: src/valve_peak_hold_sequencer.sv
// top level of the valve peak-and-hold sequencer
// depends on vphs_pkg for item, command and register codes
`timescale 1ns / 1ps
`default_nettype none

// Peak-and-hold sequencer for one solenoid valve. Items arrive on the item channel (op,
// elapsed_us, command) and each one produces exactly one result (drive_write, duty,
// valve_state). One item is taken every clock cycle while item_stall is low; each item passes
// through the input register and then the result register, and an empty input register can
// take the next item while a result waits on result_stall. The valve state, the saturating
// microsecond timer and the last written duty live in registers that the result stage updates,
// so each item sees everything that earlier items left behind. The worst path is one 32-bit
// saturating add followed by a 32-bit compare. Configuration registers are written through
// wr_en / wr_index / wr_data with no wait; an index past the register list is dropped. Write
// them only while no item is in flight. After reset the state is closed, the timer and last
// duty are zero, hold duty is 50 and full duty is 255.
module valve_peak_hold_sequencer
	import vphs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write port
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [TIMER_W-1:0]   wr_data,
	// item channel
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire logic [1:0]           op,
	input  wire logic [ELAPSED_W-1:0] elapsed_us,
	input  wire logic [1:0]           command,
	// result channel
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic                      drive_write,
	output logic [DUTY_W-1:0]         duty,
	output logic [2:0]                valve_state
);

	typedef enum logic [2:0] {
		ST_CLOSED     = 3'd0,
		ST_OPEN       = 3'd1,
		ST_FIRE_CMD   = 3'd2,
		ST_OPEN_CMD   = 3'd3,
		ST_CLOSE_CMD  = 3'd4,
		ST_OPEN_PROC  = 3'd5,
		ST_CLOSE_PROC = 3'd6
	} vstate_t;

	// configuration
	logic               normally_open_q;
	logic [TIMER_W-1:0] fire_delay_q;
	logic [TIMER_W-1:0] full_time_q;
	logic [DUTY_W-1:0]  hold_duty_q;
	logic [DUTY_W-1:0]  full_duty_q;

	// input register
	logic                 valid_s1;
	logic [1:0]           op_s1;
	logic [ELAPSED_W-1:0] elapsed_s1;
	logic [1:0]           cmd_s1;

	// sequencer state
	vstate_t            state_q;
	logic [TIMER_W-1:0] timer_q;
	logic [DUTY_W-1:0]  last_duty_q;

	// result register
	logic              result_valid_q;
	logic              drive_write_q;
	logic [DUTY_W-1:0] duty_q;
	vstate_t           result_state_q;

	// next-state values for the item in the input register
	vstate_t            state_n;
	logic [TIMER_W-1:0] timer_n;
	logic [DUTY_W-1:0]  last_duty_n;
	logic               wrote;
	logic [TIMER_W:0]   sum_wide;
	logic [TIMER_W-1:0] timer_sum;

	// the input stage moves on whenever the result register is empty or being drained
	logic advance;
	// the input register takes a new item when it moves on or when it is empty
	logic load_s1;
	assign advance    = !result_valid_q || !result_stall;
	assign load_s1    = advance || !valid_s1;
	assign item_stall = !load_s1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normally_open_q <= 1'b0;
			fire_delay_q    <= '0;
			full_time_q     <= '0;
			hold_duty_q     <= HOLD_DUTY_RST;
			full_duty_q     <= FULL_DUTY_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_NORMALLY_OPEN:  normally_open_q <= wr_data[0];
				REG_FIRE_DELAY:     fire_delay_q    <= wr_data;
				REG_FULL_DUTY_TIME: full_time_q     <= wr_data;
				REG_HOLD_DUTY:      hold_duty_q     <= wr_data[DUTY_W-1:0];
				REG_FULL_DUTY:      full_duty_q     <= wr_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// input register: loads on each item transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && item_valid) begin
			op_s1      <= op;
			elapsed_s1 <= elapsed_us;
			cmd_s1     <= command;
		end
	end

	// saturating timer add, only kept on a step
	assign sum_wide  = {1'b0, timer_q} + {{(TIMER_W + 1 - ELAPSED_W){1'b0}}, elapsed_s1};
	assign timer_sum = sum_wide[TIMER_W] ? {TIMER_W{1'b1}} : sum_wide[TIMER_W-1:0];

	// state rule
	always_comb begin
		state_n     = state_q;
		timer_n     = timer_q;
		last_duty_n = last_duty_q;
		wrote       = 1'b0;
		case (op_s1)
			OP_STEP: begin
				timer_n = timer_sum;
				case (state_q)
					ST_FIRE_CMD: begin
						if (timer_sum >= fire_delay_q) begin
							state_n = normally_open_q ? ST_CLOSE_CMD : ST_OPEN_CMD;
							timer_n = '0;
						end
					end
					ST_OPEN_CMD: begin
						wrote   = 1'b1;
						timer_n = '0;
						if (normally_open_q) begin
							last_duty_n = DUTY_OFF;
							state_n     = ST_OPEN;
						end else begin
							last_duty_n = full_duty_q;
							state_n     = ST_OPEN_PROC;
						end
					end
					ST_CLOSE_CMD: begin
						wrote   = 1'b1;
						timer_n = '0;
						if (normally_open_q) begin
							last_duty_n = full_duty_q;
							state_n     = ST_CLOSE_PROC;
						end else begin
							last_duty_n = DUTY_OFF;
							state_n     = ST_CLOSED;
						end
					end
					ST_OPEN_PROC, ST_CLOSE_PROC: begin
						// pull-in done: drop to hold duty
						if (timer_sum >= full_time_q) begin
							wrote       = 1'b1;
							last_duty_n = hold_duty_q;
							timer_n     = '0;
							state_n     = (state_q == ST_OPEN_PROC) ? ST_OPEN : ST_CLOSED;
						end
					end
					ST_CLOSED: begin
						// normally closed valve keeps re-asserting off
						if (!normally_open_q) begin
							wrote       = 1'b1;
							last_duty_n = DUTY_OFF;
						end
					end
					default: ;
				endcase
			end
			OP_COMMAND: begin
				case (cmd_s1)
					CMD_FIRE: begin
						state_n = ST_FIRE_CMD;
						timer_n = '0;
					end
					CMD_OPEN: begin
						state_n = ST_OPEN_CMD;
						timer_n = '0;
					end
					CMD_CLOSE: begin
						state_n = ST_CLOSE_CMD;
						timer_n = '0;
					end
					default: ;  // unknown command is ignored
				endcase
			end
			OP_TIMER_CLR: timer_n = '0;
			default: ;  // unknown op is ignored
		endcase
	end

	// sequencer state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLOSED;
			timer_q        <= '0;
			last_duty_q    <= '0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q     <= state_n;
				timer_q     <= timer_n;
				last_duty_q <= last_duty_n;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			drive_write_q  <= wrote;
			duty_q         <= last_duty_n;
			result_state_q <= state_n;
		end
	end

	assign result_valid = result_valid_q;
	assign drive_write  = drive_write_q;
	assign duty         = duty_q;
	assign valve_state  = result_state_q;

	// only a step item may write a duty
	a_write_only_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && op_s1 != OP_STEP |=> !drive_write_q)
		else $error("duty write from a non-step item");

	// a step out of open_cmd always writes a duty
	a_open_cmd_writes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && op_s1 == OP_STEP && state_q == ST_OPEN_CMD |=> drive_write_q)
		else $error("open_cmd step without duty write");

	// timer reset item clears the timer
	a_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && op_s1 == OP_TIMER_CLR |=> timer_q == '0)
		else $error("timer not cleared");

	// the item channel stalls only when the input register holds an item
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid_q)
		else $error("item stall with nothing held");

	// result state matches the sequencer state right after an update
	a_result_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 |=> result_state_q == state_q)
		else $error("result state differs from sequencer state");

endmodule

`default_nettype wire
